// File: rtl/pru_pkg.sv
// Shared types and constants for the pixel replication upscaler.
// Used by pru_front, pru_back and pixel_replication_upscaler_top; no dependencies.
package pru_pkg;

  localparam int SCALE_W = 7;
  localparam int SRCW_W  = 11;
  localparam int SRCH_W  = 16;
  localparam int PIX_W   = 24;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [SCALE_W-1:0] SCALE_MAX = 7'd100;

  // Output queue between the front and back parts
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;
  localparam int QCNT_W  = 3;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_PULL = 1'b1;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_SCALE      = 2'd0;
  localparam logic [1:0] REG_SRC_WIDTH  = 2'd1;
  localparam logic [1:0] REG_SRC_HEIGHT = 2'd2;

  typedef enum logic [1:0] {
    ST_LOADED    = 2'd0,
    ST_PIXEL     = 2'd1,
    ST_NOT_READY = 2'd2,
    ST_BUSY      = 2'd3
  } status_e;

  typedef struct packed {
    logic [SCALE_W-1:0] scale;
    logic [SRCW_W-1:0]  src_width;
    logic [SRCH_W-1:0]  src_height;
  } cfg_t;

  // Classified item handed from the front part to the back part
  typedef struct packed {
    status_e    status;
    logic       pix_en;
    logic [1:0] pad_bytes;
    logic       row_end;
    logic       frame_end;
  } cmd_t;

  // Padding bytes: (width * scale) mod 4, only the low two bits matter
  function automatic logic [1:0] pad_of(input logic [1:0] w_lo, input logic [1:0] s_lo);
    logic [3:0] prod;
    prod = {2'b00, w_lo} * {2'b00, s_lo};
    return prod[1:0];
  endfunction

endpackage

// File: rtl/pru_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pru_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/pru_front.sv
// Front part: accepts items, runs the load/pull counters, drives the line buffer
// ports and registers one classified command per item. Depends on pru_pkg.
module pru_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pru_pkg::cfg_t                 cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          operation_i,
  input  logic [pru_pkg::PIX_W-1:0]     pixel_in_i,
  input  logic [pru_pkg::QCNT_W-1:0]    q_level_i,
  output logic                          cmd_valid_o,
  output pru_pkg::cmd_t                 cmd_o,
  output logic                          ram_we_o,
  output logic [(MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1)-1:0] ram_waddr_o,
  output logic [pru_pkg::PIX_W-1:0]     ram_wdata_o,
  output logic                          ram_re_o,
  output logic [(MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1)-1:0] ram_raddr_o
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int WW = (CW > pru_pkg::SRCW_W) ? CW : pru_pkg::SRCW_W;
  localparam int SW = pru_pkg::SCALE_W;
  localparam int HW = pru_pkg::SRCH_W;

  logic                 accept;
  logic [WW-1:0]        eff_w;
  logic [WW-1:0]        wide_w;
  logic [SW-1:0]        eff_s;
  logic [HW:0]          eff_h;
  logic [pru_pkg::QCNT_W:0] occupancy;

  logic [AW-1:0] load_cnt_q, load_cnt_d;
  logic          row_ready_q, row_ready_d;
  logic [AW-1:0] col_q, col_d;
  logic [SW-1:0] rep_q, rep_d;
  logic [SW-1:0] rrep_q, rrep_d;
  logic [HW-1:0] rows_q, rows_d;
  logic          cmd_valid_q;
  pru_pkg::cmd_t cmd_q, cmd_d;

  logic [WW-1:0] load_nxt;
  logic [WW-1:0] col_inc;
  logic [WW-1:0] col_mid;
  logic [SW-1:0] rep_inc;
  logic [SW-1:0] rrep_inc;
  logic [HW:0]   rows_inc;

  // Room is counted against queue entries plus the command in flight
  assign occupancy  = {1'b0, q_level_i} + {{pru_pkg::QCNT_W{1'b0}}, cmd_valid_q};
  assign in_stall_o = (occupancy >= (pru_pkg::QCNT_W+1)'(pru_pkg::QDEPTH));
  assign accept     = in_valid_i & ~in_stall_o;

  assign wide_w = WW'(cfg_i.src_width);
  always_comb begin
    if (cfg_i.src_width == '0) begin
      eff_w = WW'(1);
    end else if (wide_w > WW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = wide_w;
    end
    if (cfg_i.scale == '0) begin
      eff_s = SW'(1);
    end else if (cfg_i.scale > pru_pkg::SCALE_MAX) begin
      eff_s = pru_pkg::SCALE_MAX;
    end else begin
      eff_s = cfg_i.scale;
    end
    eff_h = (cfg_i.src_height == '0) ? (HW+1)'(1) : {1'b0, cfg_i.src_height};
  end

  assign load_nxt = WW'(load_cnt_q) + WW'(1);
  assign col_inc  = WW'(col_q) + WW'(1);
  assign rep_inc  = rep_q + SW'(1);
  assign rrep_inc = rrep_q + SW'(1);
  assign rows_inc = {1'b0, rows_q} + (HW+1)'(1);
  assign col_mid  = (rep_inc >= eff_s) ? col_inc : WW'(col_q);

  always_comb begin
    load_cnt_d  = load_cnt_q;
    row_ready_d = row_ready_q;
    col_d       = col_q;
    rep_d       = rep_q;
    rrep_d      = rrep_q;
    rows_d      = rows_q;
    cmd_d       = '{status: pru_pkg::ST_LOADED, pix_en: 1'b0, pad_bytes: 2'b00,
                    row_end: 1'b0, frame_end: 1'b0};
    if (operation_i == pru_pkg::OP_LOAD) begin
      if (row_ready_q) begin
        cmd_d.status = pru_pkg::ST_BUSY;
      end else if (load_nxt >= eff_w) begin
        load_cnt_d  = '0;
        row_ready_d = 1'b1;
        col_d       = '0;
        rep_d       = '0;
        rrep_d      = '0;
      end else begin
        load_cnt_d  = load_nxt[AW-1:0];
      end
    end else if (!row_ready_q) begin
      cmd_d.status = pru_pkg::ST_NOT_READY;
    end else begin
      cmd_d.status = pru_pkg::ST_PIXEL;
      cmd_d.pix_en = 1'b1;
      rep_d        = (rep_inc >= eff_s) ? '0 : rep_inc;
      col_d        = col_mid[AW-1:0];
      if (col_mid >= eff_w) begin
        // last pixel of this output row
        col_d           = '0;
        rep_d           = '0;
        cmd_d.row_end   = 1'b1;
        cmd_d.pad_bytes = pru_pkg::pad_of(eff_w[1:0], eff_s[1:0]);
        rrep_d          = rrep_inc;
        if (rrep_inc >= eff_s) begin
          rrep_d      = '0;
          row_ready_d = 1'b0;
          rows_d      = rows_inc[HW-1:0];
          if (rows_inc >= eff_h) begin
            rows_d          = '0;
            cmd_d.frame_end = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q  <= '0;
      row_ready_q <= 1'b0;
      col_q       <= '0;
      rep_q       <= '0;
      rrep_q      <= '0;
      rows_q      <= '0;
      cmd_valid_q <= 1'b0;
    end else begin
      cmd_valid_q <= accept;
      if (accept) begin
        load_cnt_q  <= load_cnt_d;
        row_ready_q <= row_ready_d;
        col_q       <= col_d;
        rep_q       <= rep_d;
        rrep_q      <= rrep_d;
        rows_q      <= rows_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_valid_o = cmd_valid_q;
  assign cmd_o       = cmd_q;

  assign ram_we_o    = accept & (operation_i == pru_pkg::OP_LOAD) & ~row_ready_q;
  assign ram_waddr_o = load_cnt_q;
  assign ram_wdata_o = pixel_in_i;
  assign ram_re_o    = accept & (operation_i == pru_pkg::OP_PULL) & row_ready_q;
  assign ram_raddr_o = col_q;

endmodule

// File: rtl/pru_back.sv
// Back part: joins each command with its line buffer data and queues the
// finished result items toward the output channel. Depends on pru_pkg.
module pru_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  input  pru_pkg::cmd_t              cmd_i,
  input  logic [pru_pkg::PIX_W-1:0]  rdata_i,
  output logic [pru_pkg::QCNT_W-1:0] q_level_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 status_o,
  output logic [pru_pkg::PIX_W-1:0]  pixel_out_o,
  output logic [1:0]                 pad_bytes_o,
  output logic                       row_end_o,
  output logic                       frame_end_o
);

  pru_pkg::cmd_t              cmd_mem [pru_pkg::QDEPTH];
  logic [pru_pkg::PIX_W-1:0]  pix_mem [pru_pkg::QDEPTH];
  logic [pru_pkg::QPTR_W-1:0] wptr_q, rptr_q;
  logic [pru_pkg::QCNT_W-1:0] cnt_q, cnt_d;
  logic                       pop;
  pru_pkg::cmd_t              head;

  assign pop   = out_valid_o & ~out_stall_i;
  assign cnt_d = cnt_q + pru_pkg::QCNT_W'(cmd_valid_i) - pru_pkg::QCNT_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_valid_i) begin
        wptr_q <= wptr_q + pru_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rptr_q <= rptr_q + pru_pkg::QPTR_W'(1);
      end
    end
  end

  // Front never pushes into a full queue, so no full check here
  always_ff @(posedge clk_i) begin
    if (cmd_valid_i) begin
      cmd_mem[wptr_q] <= cmd_i;
      pix_mem[wptr_q] <= cmd_i.pix_en ? rdata_i : '0;
    end
  end

  assign head        = cmd_mem[rptr_q];
  assign q_level_o   = cnt_q;
  assign out_valid_o = (cnt_q != '0);
  assign status_o    = head.status;
  assign pixel_out_o = pix_mem[rptr_q];
  assign pad_bytes_o = head.pad_bytes;
  assign row_end_o   = head.row_end;
  assign frame_end_o = head.frame_end;

endmodule

// File: rtl/pixel_replication_upscaler_top.sv
// Top level of the pixel replication upscaler: register port, line buffer,
// front and back parts. Depends on pru_pkg, pru_ram, pru_front, pru_back.
//
//   channel  direction  handshake                   payload
//   input    in         in_valid_i / in_stall_o     operation_i, pixel_in_i
//   result   out        out_valid_o / out_stall_i   status_o, pixel_out_o, pad_bytes_o,
//                                                   row_end_o, frame_end_o
//   config   in/out     psel, penable, pwrite       paddr, pwdata, prdata, pready
//
// One item per clock while in_stall_o is low; each accepted item's command and line buffer read
// data are registered together, then written into the result queue that drives the outputs.
// Throughput is set by the single line buffer read port: one entry per pull.
// Reset clears all counters and the queue; the line buffer holds no reset value.
// in_stall_o rises when the result queue entries plus the command in flight reach the depth of four.
module pixel_replication_upscaler_top #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         operation_i,
  input  logic [pru_pkg::PIX_W-1:0]    pixel_in_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   status_o,
  output logic [pru_pkg::PIX_W-1:0]    pixel_out_o,
  output logic [1:0]                   pad_bytes_o,
  output logic                         row_end_o,
  output logic                         frame_end_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pru_pkg::ADDR_W-1:0]   paddr,
  input  logic [pru_pkg::DATA_W-1:0]   pwdata,
  output logic [pru_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  pru_pkg::cfg_t              cfg_q;
  logic                       cfg_we;
  logic [1:0]                 reg_idx;
  logic                       cmd_valid;
  pru_pkg::cmd_t              cmd;
  logic [pru_pkg::QCNT_W-1:0] q_level;
  logic                       ram_we, ram_re;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [pru_pkg::PIX_W-1:0]  ram_wdata, ram_rdata;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_we  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scale      <= pru_pkg::SCALE_W'(1);
      cfg_q.src_width  <= pru_pkg::SRCW_W'(1);
      cfg_q.src_height <= pru_pkg::SRCH_W'(1);
    end else if (cfg_we) begin
      case (reg_idx)
        pru_pkg::REG_SCALE:      cfg_q.scale      <= pwdata[pru_pkg::SCALE_W-1:0];
        pru_pkg::REG_SRC_WIDTH:  cfg_q.src_width  <= pwdata[pru_pkg::SRCW_W-1:0];
        pru_pkg::REG_SRC_HEIGHT: cfg_q.src_height <= pwdata[pru_pkg::SRCH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      pru_pkg::REG_SCALE:      prdata = pru_pkg::DATA_W'(cfg_q.scale);
      pru_pkg::REG_SRC_WIDTH:  prdata = pru_pkg::DATA_W'(cfg_q.src_width);
      pru_pkg::REG_SRC_HEIGHT: prdata = pru_pkg::DATA_W'(cfg_q.src_height);
      default:                 prdata = '0;
    endcase
  end

  pru_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .pixel_in_i  (pixel_in_i),
    .q_level_i   (q_level),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr)
  );

  pru_ram #(
    .WIDTH(pru_pkg::PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  pru_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .rdata_i     (ram_rdata),
    .q_level_o   (q_level),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .pixel_out_o (pixel_out_o),
    .pad_bytes_o (pad_bytes_o),
    .row_end_o   (row_end_o),
    .frame_end_o (frame_end_o)
  );

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for pixel_replication_upscaler_top: directed and random
// load/pull items, APB register writes, random gaps and stalls. Depends on pru_pkg and the top.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LINE_DEPTH     = 1024;
  localparam int unsigned WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    pru_pkg::status_e           status;
    logic [pru_pkg::PIX_W-1:0]  pixel;
    logic [1:0]                 pad;
    logic                       row_end;
    logic                       frame_end;
  } pixel_result_t;

  class upscale_scoreboard;
    logic [pru_pkg::PIX_W-1:0]   line_mem [LINE_DEPTH];
    logic [pru_pkg::SCALE_W-1:0] scale_r;
    logic [pru_pkg::SRCW_W-1:0]  width_r;
    logic [pru_pkg::SRCH_W-1:0]  height_r;
    int unsigned fill_idx, defined_cnt, col, rep, row_rep, rows_out;
    bit row_held;
    pixel_result_t due_results[$];
    int unsigned errors;

    function new();
      scale_r = pru_pkg::SCALE_W'(1);
      width_r = pru_pkg::SRCW_W'(1);
      height_r = pru_pkg::SRCH_W'(1);
      fill_idx = 0;
      defined_cnt = 0;
      col = 0;
      rep = 0;
      row_rep = 0;
      rows_out = 0;
      row_held = 1'b0;
      errors = 0;
    endfunction

    function int unsigned eff_scale();
      if (scale_r == 0) return 1;
      if (scale_r > pru_pkg::SCALE_MAX) return 32'(pru_pkg::SCALE_MAX);
      return 32'(scale_r);
    endfunction

    function int unsigned eff_width();
      if (width_r == 0) return 1;
      if (width_r > LINE_DEPTH) return LINE_DEPTH;
      return 32'(width_r);
    endfunction

    function int unsigned eff_height();
      return (height_r == 0) ? 1 : 32'(height_r);
    endfunction

    function void set_reg(logic [1:0] idx, logic [pru_pkg::DATA_W-1:0] val);
      case (idx)
        pru_pkg::REG_SCALE:      scale_r = val[pru_pkg::SCALE_W-1:0];
        pru_pkg::REG_SRC_WIDTH:  width_r = val[pru_pkg::SRCW_W-1:0];
        pru_pkg::REG_SRC_HEIGHT: height_r = val[pru_pkg::SRCH_W-1:0];
        default: ;
      endcase
    endfunction

    // Advance the upscaler state by one accepted item and queue its result
    function void step_upscaler(logic op, logic [pru_pkg::PIX_W-1:0] pix);
      pixel_result_t r;
      int unsigned w, s, h;
      w = eff_width();
      s = eff_scale();
      h = eff_height();
      r = '0;
      r.status = pru_pkg::ST_LOADED;
      if (op == pru_pkg::OP_LOAD) begin
        if (row_held) begin
          r.status = pru_pkg::ST_BUSY;
        end else begin
          line_mem[fill_idx] = pix;
          fill_idx++;
          if (fill_idx > defined_cnt) defined_cnt = fill_idx;
          if (fill_idx >= w) begin
            fill_idx = 0;
            row_held = 1'b1;
            col = 0;
            rep = 0;
            row_rep = 0;
          end
        end
      end else if (!row_held) begin
        r.status = pru_pkg::ST_NOT_READY;
      end else begin
        r.status = pru_pkg::ST_PIXEL;
        r.pixel = line_mem[col];
        rep++;
        if (rep >= s) begin
          rep = 0;
          col++;
        end
        // limits are "at or above", so a lowered register ends the run at once
        if (col >= w) begin
          col = 0;
          rep = 0;
          r.row_end = 1'b1;
          r.pad = 2'(w * s);
          row_rep++;
          if (row_rep >= s) begin
            row_rep = 0;
            row_held = 1'b0;
            rows_out++;
            if (rows_out >= h) begin
              rows_out = 0;
              r.frame_end = 1'b1;
            end
          end
        end
      end
      due_results.push_back(r);
    endfunction

    function void compare(string name, logic [pru_pkg::PIX_W-1:0] want,
                          logic [pru_pkg::PIX_W-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(pixel_result_t got);
      pixel_result_t want;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual status %0d pixel %0h",
                 $time, got.status, got.pixel);
        return;
      end
      want = due_results.pop_front();
      compare("status", pru_pkg::PIX_W'(want.status), pru_pkg::PIX_W'(got.status));
      compare("pixel_out", want.pixel, got.pixel);
      compare("pad_bytes", pru_pkg::PIX_W'(want.pad), pru_pkg::PIX_W'(got.pad));
      compare("row_end", pru_pkg::PIX_W'(want.row_end), pru_pkg::PIX_W'(got.row_end));
      compare("frame_end", pru_pkg::PIX_W'(want.frame_end),
              pru_pkg::PIX_W'(got.frame_end));
    endfunction
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic                         operation_i;
  logic [pru_pkg::PIX_W-1:0]    pixel_in_i;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic [1:0]                   status_o;
  logic [pru_pkg::PIX_W-1:0]    pixel_out_o;
  logic [1:0]                   pad_bytes_o;
  logic                         row_end_o;
  logic                         frame_end_o;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [pru_pkg::ADDR_W-1:0]   paddr;
  logic [pru_pkg::DATA_W-1:0]   pwdata;
  logic [pru_pkg::DATA_W-1:0]   prdata;
  logic                         pready;

  upscale_scoreboard sb = new();
  int unsigned send_gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned quiet_cycles = 0;

  pixel_replication_upscaler_top #(.MAX_WIDTH(LINE_DEPTH)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .operation_i(operation_i), .pixel_in_i(pixel_in_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .status_o(status_o), .pixel_out_o(pixel_out_o), .pad_bytes_o(pad_bytes_o),
    .row_end_o(row_end_o), .frame_end_o(frame_end_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(negedge clk_i) out_stall_i <= ($urandom_range(0, 99) < stall_pct);

  always @(posedge clk_i) begin
    pixel_result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.status = pru_pkg::status_e'(status_o);
      got.pixel = pixel_out_o;
      got.pad = pad_bytes_o;
      got.row_end = row_end_o;
      got.frame_end = frame_end_o;
      sb.check_result(got);
    end
    if (rst_ni && !((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)))
      quiet_cycles++;
    else
      quiet_cycles = 0;
  end

  initial begin
    do @(posedge clk_i); while (quiet_cycles < WATCHDOG_LIMIT);
    $display("pixel_replication_upscaler_top regression: fail");
    $finish;
  end

  task automatic send_item(logic op, logic [pru_pkg::PIX_W-1:0] pix);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    pixel_in_i <= pix;
    do @(posedge clk_i); while (in_stall_o);
    sb.step_upscaler(op, pix);
  endtask

  // Sender holds off until every queued result has come back
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [pru_pkg::DATA_W-1:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, val);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic complete_row();
    while (!sb.row_held) send_item(pru_pkg::OP_LOAD, pru_pkg::PIX_W'($urandom));
    while (sb.row_held) send_item(pru_pkg::OP_PULL, pru_pkg::PIX_W'($urandom));
  endtask

  function automatic logic [pru_pkg::DATA_W-1:0] pick_scale();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) return 0;
    if (r < 12) return pru_pkg::DATA_W'(pru_pkg::SCALE_MAX);
    if (r < 16) return $urandom_range(101, 127);
    if (r < 20) return 1;
    return $urandom_range(1, 4);
  endfunction

  function automatic logic [pru_pkg::DATA_W-1:0] pick_height();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return 0;
    if (r < 10) return 65535;
    return $urandom_range(1, 3);
  endfunction

  // A held row must never be widened past the entries loaded so far
  function automatic logic [pru_pkg::DATA_W-1:0] pick_width();
    int unsigned r, v, eff;
    r = $urandom_range(0, 99);
    if (r < 5) v = 0;
    else if (r < 10) v = $urandom_range(LINE_DEPTH, 2047);
    else if (r < 15) v = 1;
    else v = $urandom_range(1, 8);
    eff = (v == 0) ? 1 : ((v > LINE_DEPTH) ? LINE_DEPTH : v);
    if (sb.row_held && eff > sb.defined_cnt) v = $urandom_range(1, sb.defined_cnt);
    return v;
  endfunction

  function automatic logic pick_op();
    if (sb.row_held) begin
      return ($urandom_range(0, 99) < 6) ? pru_pkg::OP_LOAD : pru_pkg::OP_PULL;
    end
    return ($urandom_range(0, 99) < 8) ? pru_pkg::OP_PULL : pru_pkg::OP_LOAD;
  endfunction

  task automatic run_random_phase(int unsigned n_items);
    int unsigned k;
    drain();
    write_reg(pru_pkg::REG_SCALE, pick_scale());
    write_reg(pru_pkg::REG_SRC_HEIGHT, pick_height());
    write_reg(pru_pkg::REG_SRC_WIDTH, pick_width());
    for (k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 39) == 0) begin
        drain();
        case ($urandom_range(0, 2))
          0: write_reg(pru_pkg::REG_SCALE, pick_scale());
          1: write_reg(pru_pkg::REG_SRC_WIDTH, pick_width());
          default: write_reg(pru_pkg::REG_SRC_HEIGHT, pick_height());
        endcase
      end
      send_item(pick_op(), pru_pkg::PIX_W'($urandom));
    end
  endtask

  initial begin
    int unsigned m, p;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    operation_i = pru_pkg::OP_LOAD;
    pixel_in_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset config is 1x1 pixel, one row per frame
    send_item(pru_pkg::OP_PULL, 24'h000000);
    send_item(pru_pkg::OP_LOAD, 24'hFFFFFF);
    send_item(pru_pkg::OP_LOAD, 24'h000000);
    send_item(pru_pkg::OP_PULL, 24'hFFFFFF);
    drain();
    write_reg(pru_pkg::REG_SCALE, 2);
    write_reg(pru_pkg::REG_SRC_WIDTH, 3);
    write_reg(pru_pkg::REG_SRC_HEIGHT, 1);
    send_item(pru_pkg::OP_LOAD, 24'h000000);
    send_item(pru_pkg::OP_LOAD, 24'hFFFFFF);
    send_item(pru_pkg::OP_LOAD, 24'h5AA55A);
    while (sb.row_held) send_item(pru_pkg::OP_PULL, pru_pkg::PIX_W'($urandom));

    // saturated scale, then lowered while a pixel is half replicated
    drain();
    write_reg(pru_pkg::REG_SCALE, 127);
    write_reg(pru_pkg::REG_SRC_WIDTH, 2);
    write_reg(pru_pkg::REG_SRC_HEIGHT, 65535);
    while (!sb.row_held) send_item(pru_pkg::OP_LOAD, pru_pkg::PIX_W'($urandom));
    repeat (60) send_item(pru_pkg::OP_PULL, pru_pkg::PIX_W'($urandom));
    drain();
    write_reg(pru_pkg::REG_SCALE, 3);
    while (sb.row_held) send_item(pru_pkg::OP_PULL, pru_pkg::PIX_W'($urandom));
    drain();
    write_reg(pru_pkg::REG_SRC_HEIGHT, 1);
    complete_row();

    // saturated width, zero height, then the width cut below the fill level
    drain();
    write_reg(pru_pkg::REG_SCALE, 1);
    write_reg(pru_pkg::REG_SRC_WIDTH, 2047);
    write_reg(pru_pkg::REG_SRC_HEIGHT, 0);
    repeat (40) send_item(pru_pkg::OP_LOAD, pru_pkg::PIX_W'($urandom));
    drain();
    write_reg(pru_pkg::REG_SRC_WIDTH, 5);
    complete_row();
    drain();
    write_reg(pru_pkg::REG_SCALE, 0);
    write_reg(pru_pkg::REG_SRC_WIDTH, 0);
    complete_row();

    for (m = 0; m < 4; m++) begin
      case (m)
        0: begin send_gap_pct = 0; stall_pct = 0; end
        1: begin send_gap_pct = 88; stall_pct = 0; end
        2: begin send_gap_pct = 0; stall_pct = 88; end
        default: begin send_gap_pct = 15; stall_pct = 15; end
      endcase
      for (p = 0; p < 5; p++) run_random_phase(54);
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.due_results.size() == 0)
      $display("pixel_replication_upscaler_top regression: pass");
    else
      $display("pixel_replication_upscaler_top regression: fail");
    $finish;
  end

endmodule
